// ===== rtl/urgent_front_event_queue_macros.svh =====
// assertion macros for the urgent front event queue
// used by rtl files that check their own logic; expects aclk and aresetn in scope
`ifndef URGENT_FRONT_EVENT_QUEUE_MACROS_SVH
`define URGENT_FRONT_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define UFEQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define UFEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ufeq_pkg.sv =====
// shared constants for the urgent front event queue
// no dependencies; imported by every rtl module of the block but ufeq_ram
package ufeq_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int TASK_W   = 8;
    localparam int CODE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int WIDE_W   = 64;

    // defaults for the top level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_PARAM_WIDTH = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MAX_TASK_ID = 1'b0;
    localparam logic [TASK_W-1:0] MAX_TASK_ID_RESET = 8'd15;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TASK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_HEAD = 3'd4;

endpackage

// ===== rtl/ufeq_ram.sv =====
// entry store of the event queue: one write port, one registered read port
// a write to the address being read is forwarded into the read register
module ufeq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ufeq_cfg.sv =====
// configuration register file of the event queue (apb-style write and read)
// depends on ufeq_pkg for the register map and reset value
module ufeq_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ufeq_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ufeq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ufeq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [ufeq_pkg::TASK_W-1:0]      max_task_id
);
    import ufeq_pkg::*;

    logic [TASK_W-1:0] max_task_id_reg;
    logic              reg_hit;

    // word index is everything above the byte offset
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_TASK_ID);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_task_id_reg <= MAX_TASK_ID_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            max_task_id_reg <= pwdata[TASK_W-1:0];
        end
    end

    assign prdata      = reg_hit ? APB_DATA_W'(max_task_id_reg) : '0;
    assign pready      = 1'b1;
    assign max_task_id = max_task_id_reg;

endmodule

// ===== rtl/ufeq_core.sv =====
// command engine of the event queue: input register, head/count update, result register
// depends on ufeq_pkg and the assertion macros; drives the entry store ports
`include "urgent_front_event_queue_macros.svh"

module ufeq_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PARAM_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5,
    parameter int ENTRY_W     = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ufeq_pkg::CMD_W-1:0]     s_command,
    input  logic                           s_urgent,
    input  logic [ufeq_pkg::TASK_W-1:0]    s_task_id,
    input  logic [ufeq_pkg::CODE_W-1:0]    s_event_code,
    input  logic [ufeq_pkg::WORD_W-1:0]    s_param_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ufeq_pkg::STATUS_W-1:0]  m_status,
    output logic [ufeq_pkg::TASK_W-1:0]    m_out_task_id,
    output logic [ufeq_pkg::CODE_W-1:0]    m_out_event_code,
    output logic [ufeq_pkg::WORD_W-1:0]    m_out_param_word,
    output logic [CNT_W-1:0]               m_fill_count,
    input  logic [ufeq_pkg::TASK_W-1:0]    max_task_id,
    output logic                           wr_en,
    output logic [IDX_W-1:0]               wr_addr,
    output logic [ENTRY_W-1:0]             wr_data,
    output logic [IDX_W-1:0]               rd_addr,
    input  logic [ENTRY_W-1:0]             rd_data
);
    import ufeq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // input register
    logic                 in_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic                 urg_reg;
    logic [TASK_W-1:0]    task_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [WORD_W-1:0]    param_reg;

    // queue state
    logic [IDX_W-1:0]     head_reg;
    logic [CNT_W-1:0]     count_reg;

    // result register
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [TASK_W-1:0]    out_task_reg;
    logic [CODE_W-1:0]    out_code_reg;
    logic [WORD_W-1:0]    out_param_reg;
    logic [CNT_W-1:0]     fill_reg;

    logic                 exec_go;
    logic [SUM_W-1:0]     tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [IDX_W-1:0]     head_dec;
    logic [IDX_W-1:0]     head_inc;
    logic [TASK_W-1:0]    head_task;
    logic [CODE_W-1:0]    head_code;
    logic [PARAM_WIDTH-1:0] head_param;
    logic [WIDE_W-1:0]    in_param_wide;
    logic [WIDE_W-1:0]    out_param_wide;

    logic [STATUS_W-1:0]  status_c;
    logic [IDX_W-1:0]     head_c;
    logic [CNT_W-1:0]     count_c;
    logic                 wr_en_c;
    logic [IDX_W-1:0]     wr_addr_c;
    logic                 pop_ok_c;

    // the item in the input register executes when the result register is free
    assign exec_go = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            urg_reg   <= s_urgent;
            task_reg  <= s_task_id;
            code_reg  <= s_event_code;
            param_reg <= s_param_word;
        end
    end

    // head entry, prefetched from the store
    assign head_task  = rd_data[ENTRY_W-1 -: TASK_W];
    assign head_code  = rd_data[PARAM_WIDTH +: CODE_W];
    assign head_param = rd_data[PARAM_WIDTH-1:0];

    // ring arithmetic; tail sum stays below twice the depth
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign head_dec = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        status_c  = ST_OK;
        head_c    = head_reg;
        count_c   = count_reg;
        wr_en_c   = 1'b0;
        wr_addr_c = tail_idx;
        pop_ok_c  = 1'b0;
        unique case (cmd_reg)
            CMD_PUSH: begin
                if (task_reg > max_task_id) begin
                    status_c = ST_BAD_TASK;
                end else if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    status_c = ST_FULL;
                end else begin
                    wr_en_c = 1'b1;
                    if (urg_reg) begin
                        head_c    = head_dec;
                        wr_addr_c = head_dec;
                    end
                    count_c = count_reg + 1'b1;
                end
            end
            CMD_POP: begin
                if (count_reg == '0) begin
                    status_c = ST_EMPTY;
                end else if (head_task == '0) begin
                    status_c = ST_BAD_HEAD;
                end else begin
                    pop_ok_c = 1'b1;
                    head_c   = head_inc;
                    count_c  = count_reg - 1'b1;
                end
            end
            CMD_DROP: begin
                if (count_reg == '0) begin
                    status_c = ST_EMPTY;
                end else begin
                    head_c  = head_inc;
                    count_c = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (exec_go) begin
            head_reg  <= head_c;
            count_reg <= count_c;
        end
    end

    // store ports: the read address follows the head so the head entry is always ready
    assign in_param_wide = WIDE_W'(param_reg);
    assign wr_en   = exec_go && wr_en_c;
    assign wr_addr = wr_addr_c;
    assign wr_data = {task_reg, code_reg, in_param_wide[PARAM_WIDTH-1:0]};
    assign rd_addr = exec_go ? head_c : head_reg;

    always_comb begin
        out_param_wide = '0;
        out_param_wide[PARAM_WIDTH-1:0] = head_param;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            status_reg    <= status_c;
            out_task_reg  <= pop_ok_c ? head_task : '0;
            out_code_reg  <= pop_ok_c ? head_code : '0;
            out_param_reg <= pop_ok_c ? out_param_wide[WORD_W-1:0] : '0;
            fill_reg      <= count_c;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_out_task_id    = out_task_reg;
    assign m_out_event_code = out_code_reg;
    assign m_out_param_word = out_param_reg;
    assign m_fill_count     = fill_reg;

    `UFEQ_ASSERT(a_count_in_range, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `UFEQ_ASSERT_NEXT(a_reject_keeps_state, exec_go && (status_c != ST_OK), $stable(head_reg) && $stable(count_reg), "rejected command changed state")
    `UFEQ_ASSERT_NEXT(a_pop_shrinks, exec_go && pop_ok_c, count_reg == $past(count_reg) - 1'b1, "pop did not shrink queue")
    `UFEQ_ASSERT_NEXT(a_urgent_new_head, exec_go && wr_en_c && urg_reg, head_reg == $past(wr_addr_c), "urgent push not at head")

endmodule

// ===== rtl/urgent_front_event_queue.sv =====
// top level of the urgent front event queue
// instantiates ufeq_cfg, ufeq_core and ufeq_ram; depends on ufeq_pkg
//
// Ring-buffer event queue for a task scheduler. Each accepted item carries
// one command (push, pop head, drop head) and yields exactly one result item
// with a status, the popped event (zero unless a pop succeeded) and the fill
// count after the command. An urgent push goes in front of the head and
// becomes the new head; a normal push goes at the tail. One item is taken
// per clock cycle in steady state, while results are accepted. An accepted
// item loads the input register; it executes and loads the result register
// once the result register is free or its result is being taken, so a held
// result stalls the input. The rate is set by the single command stage,
// which updates head and count with one increment or decrement and writes
// at most one entry; the head entry is kept prefetched from the store's
// registered read port, so a pop reads it without waiting on the store.
// max_task_id is written over the apb-style port at byte address 0 and is
// to be changed only while the queue has no item in flight. Head and count
// clear on reset; the entry store is not cleared and no clearing pass runs.
module urgent_front_event_queue #(
    parameter int QUEUE_DEPTH = ufeq_pkg::DEF_QUEUE_DEPTH,
    parameter int PARAM_WIDTH = ufeq_pkg::DEF_PARAM_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ufeq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ufeq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufeq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    // command items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ufeq_pkg::CMD_W-1:0]          s_command,
    input  logic                                s_urgent,
    input  logic [ufeq_pkg::TASK_W-1:0]         s_task_id,
    input  logic [ufeq_pkg::CODE_W-1:0]         s_event_code,
    input  logic [ufeq_pkg::WORD_W-1:0]         s_param_word,

    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ufeq_pkg::STATUS_W-1:0]       m_status,
    output logic [ufeq_pkg::TASK_W-1:0]         m_out_task_id,
    output logic [ufeq_pkg::CODE_W-1:0]         m_out_event_code,
    output logic [ufeq_pkg::WORD_W-1:0]         m_out_param_word,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    m_fill_count
);
    import ufeq_pkg::*;

    // ring index, count and entry widths all follow from the parameters
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TASK_W + CODE_W + PARAM_WIDTH;

    logic [TASK_W-1:0]  max_task_id;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // register file for the task id limit
    ufeq_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_task_id (max_task_id)
    );

    // command execution, head/count state and the result register
    ufeq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PARAM_WIDTH (PARAM_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .ENTRY_W     (ENTRY_W)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_urgent         (s_urgent),
        .s_task_id        (s_task_id),
        .s_event_code     (s_event_code),
        .s_param_word     (s_param_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_task_id    (m_out_task_id),
        .m_out_event_code (m_out_event_code),
        .m_out_param_word (m_out_param_word),
        .m_fill_count     (m_fill_count),
        .max_task_id      (max_task_id),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data)
    );

    // entry store: task id, event code, parameter word per slot
    ufeq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
